@@ hw/rtl/ll1er_pkg.sv @@
// Shared types, codes and table lookups for the LL(1) expression recognizer.
// Depends on nothing; every other file of the block but ll1er_ram imports it.

package ll1er_pkg;

	// Grammar symbols as held on the stack.
	typedef logic [3:0] sym_t;
	localparam sym_t SYM_END  = 4'd0;
	localparam sym_t SYM_E    = 4'd1;
	localparam sym_t SYM_H    = 4'd2;
	localparam sym_t SYM_T    = 4'd3;
	localparam sym_t SYM_U    = 4'd4;
	localparam sym_t SYM_F    = 4'd5;
	localparam sym_t SYM_PLUS = 4'd6;
	localparam sym_t SYM_STAR = 4'd7;
	localparam sym_t SYM_LP   = 4'd8;
	localparam sym_t SYM_RP   = 4'd9;
	localparam sym_t SYM_ID   = 4'd10;

	localparam int SYM_W   = 4;
	localparam int DEPTH_W = 5;

	// Verdict codes on the result port.
	typedef logic [1:0] verdict_t;
	localparam verdict_t VERDICT_MORE   = 2'd0;
	localparam verdict_t VERDICT_ACCEPT = 2'd1;
	localparam verdict_t VERDICT_REJECT = 2'd2;

	// Character bytes of the alphabet.
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_LP   = 8'h28;
	localparam logic [7:0] CH_RP   = 8'h29;
	localparam logic [7:0] CH_END  = 8'h24;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_Z = 8'h7A;
	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_UC_Z = 8'h5A;

	// Parse table columns, plus a code for characters outside the alphabet.
	typedef enum logic [2:0] {
		COL_PLUS, COL_STAR, COL_LP, COL_RP, COL_ID, COL_END, COL_BAD
	} col_t;

	// Productions; P_ERR marks an empty table entry.
	typedef enum logic [2:0] {
		P_ERR, P_PLUS_TH, P_STAR_FU, P_PAREN, P_TH, P_FU, P_ID, P_EPS
	} prod_t;

	// What one evaluation of the top of stack decides.
	typedef enum logic [1:0] {
		ACT_ACCEPT, ACT_REJECT, ACT_MATCH, ACT_EXPAND
	} act_kind_t;

	typedef struct packed {
		act_kind_t kind;
		prod_t     prod;
	} step_act_t;

	// Map a character byte onto its table column.
	function automatic col_t classify(logic [7:0] c);
		col_t col;
		if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
			col = COL_ID;
		end else begin
			case (c)
				CH_PLUS: col = COL_PLUS;
				CH_STAR: col = COL_STAR;
				CH_LP:   col = COL_LP;
				CH_RP:   col = COL_RP;
				CH_END:  col = COL_END;
				default: col = COL_BAD;
			endcase
		end
		return col;
	endfunction

	// Terminal symbol that a column stands for.
	function automatic sym_t col_term(col_t col);
		sym_t s;
		case (col)
			COL_PLUS: s = SYM_PLUS;
			COL_STAR: s = SYM_STAR;
			COL_LP:   s = SYM_LP;
			COL_RP:   s = SYM_RP;
			COL_ID:   s = SYM_ID;
			default:  s = SYM_END;
		endcase
		return s;
	endfunction

	// Fixed LL(1) table: nonterminal row by column.
	function automatic prod_t parse_table(sym_t nt, col_t col);
		prod_t p;
		p = P_ERR;
		case (nt)
			SYM_E: begin
				case (col) inside
					COL_LP, COL_ID: p = P_TH;
					default:        p = P_ERR;
				endcase
			end
			SYM_H: begin
				case (col) inside
					COL_PLUS:        p = P_PLUS_TH;
					COL_RP, COL_END: p = P_EPS;
					default:         p = P_ERR;
				endcase
			end
			SYM_T: begin
				case (col) inside
					COL_LP, COL_ID: p = P_FU;
					default:        p = P_ERR;
				endcase
			end
			SYM_U: begin
				case (col) inside
					COL_PLUS, COL_RP, COL_END: p = P_EPS;
					COL_STAR:                  p = P_STAR_FU;
					default:                   p = P_ERR;
				endcase
			end
			SYM_F: begin
				case (col) inside
					COL_LP:  p = P_PAREN;
					COL_ID:  p = P_ID;
					default: p = P_ERR;
				endcase
			end
			default: p = P_ERR;
		endcase
		return p;
	endfunction

	// Number of symbols on the right-hand side of a production.
	function automatic logic [1:0] prod_len(prod_t p);
		logic [1:0] n;
		case (p)
			P_PLUS_TH, P_STAR_FU, P_PAREN: n = 2'd3;
			P_TH, P_FU:                    n = 2'd2;
			P_ID:                          n = 2'd1;
			default:                       n = 2'd0;
		endcase
		return n;
	endfunction

	// Right-hand side symbol at position idx, counted left to right.
	function automatic sym_t prod_rhs(prod_t p, logic [1:0] idx);
		sym_t s;
		s = SYM_END;
		case (p)
			P_PLUS_TH: s = (idx == 2'd0) ? SYM_PLUS : (idx == 2'd1) ? SYM_T : SYM_H;
			P_STAR_FU: s = (idx == 2'd0) ? SYM_STAR : (idx == 2'd1) ? SYM_F : SYM_U;
			P_PAREN:   s = (idx == 2'd0) ? SYM_LP : (idx == 2'd1) ? SYM_E : SYM_RP;
			P_TH:      s = (idx == 2'd0) ? SYM_T : SYM_H;
			P_FU:      s = (idx == 2'd0) ? SYM_F : SYM_U;
			P_ID:      s = SYM_ID;
			default:   s = SYM_END;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/ll1er_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the recognizer's symbol stack.

module ll1er_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/ll1er_step.sv @@
// Decision unit: looks at the top of stack and the current column and
// decides accept, reject, terminal match or expansion. Depends on ll1er_pkg.

module ll1er_step import ll1er_pkg::*; (
	input  sym_t      top,
	input  col_t      col,
	output step_act_t act
);

	prod_t prod;

	assign prod = parse_table(top, col);

	// End marker settles the string; terminals must match; nonterminals expand, or reject on an empty table entry.
	always_comb begin
		act.prod = prod;
		if (top == SYM_END) begin
			act.kind = (col == COL_END) ? ACT_ACCEPT : ACT_REJECT;
		end else if (top >= SYM_PLUS) begin
			act.kind = (top == col_term(col)) ? ACT_MATCH : ACT_REJECT;
		end else if (prod == P_ERR) begin
			act.kind = ACT_REJECT;
		end else begin
			act.kind = ACT_EXPAND;
		end
	end

endmodule

@@ hw/rtl/ll1_expression_recognizer.sv @@
// Top level of the LL(1) expression recognizer: sequencer, symbol stack RAM
// and decision unit. Depends on ll1er_pkg, ll1er_ram and ll1er_step.

// One item is one character; each gives one result with the verdict and the
// stack depth. The block takes one item at a time and is not ready while it
// works. Each pass over the stack reads the top entry from the RAM, then
// decides; an expansion then pushes its symbols one at a time, and an empty
// production pushes nothing. An accept or a reject also reloads the stack
// to end marker and E. After reset the block writes the initial stack
// before it takes its first item. The stack is a RAM of STACK_DEPTH entries
// with one read and one write port, which sets the pace of one stack access
// a cycle.

module ll1_expression_recognizer import ll1er_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_in,
	input  logic               in_valid,
	output logic               in_ready,
	output logic [1:0]         verdict,
	output logic [DEPTH_W-1:0] stack_depth,
	output logic               out_valid,
	input  logic               out_ready
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam logic [SPW:0] DEPTH_LIM = (SPW + 1)'(STACK_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_EVAL = 7'b0000100,
		ST_PUSH = 7'b0001000,
		ST_RLD0 = 7'b0010000,
		ST_RLD1 = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [SPW-1:0]  sp_q;
	logic [SPW-1:0]  sp_dec;
	col_t            col_q;
	prod_t           prod_q;
	logic [1:0]      cnt_q;
	logic [1:0]      cnt_dec;
	verdict_t        res_q;
	logic            rld_out_q;
	logic            out_valid_q;
	verdict_t        verdict_q;
	logic [DEPTH_W-1:0] depth_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	sym_t            ram_wdata;
	sym_t            ram_rdata;
	step_act_t       act;
	logic [SPW:0]    need;
	logic            overflow;
	logic            out_load;

	assign sp_dec  = sp_q - SPW'(1);
	assign cnt_dec = cnt_q - 2'd1;

	// Stack after popping the nonterminal, plus the production's symbols.
	assign need     = {1'b0, sp_dec} + (SPW + 1)'(prod_len(act.prod));
	assign overflow = need > DEPTH_LIM;

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Symbol stack storage.
	ll1er_ram #(
		.WIDTH(SYM_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(sp_dec[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Decision on the symbol just read from the top of the stack.
	ll1er_step u_step (
		.top(ram_rdata),
		.col(col_q),
		.act(act)
	);

	// Stack writes: pushes of a production, or the reload to end marker and E.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sp_q[AW-1:0];
		ram_wdata = prod_rhs(prod_q, cnt_dec);
		unique case (state_q)
			ST_PUSH: ram_we = 1'b1;
			ST_RLD0: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(0);
				ram_wdata = SYM_END;
			end
			ST_RLD1: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(1);
				ram_wdata = SYM_E;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RLD0;
			sp_q      <= SPW'(2);
			rld_out_q <= 1'b0;
			col_q     <= COL_BAD;
			prod_q    <= P_ERR;
			cnt_q     <= 2'd0;
			res_q     <= VERDICT_MORE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						col_q <= classify(char_in);
						if (classify(char_in) == COL_BAD) begin
							res_q     <= VERDICT_REJECT;
							rld_out_q <= 1'b1;
							state_q   <= ST_RLD0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					unique case (act.kind)
						ACT_ACCEPT: begin
							res_q     <= VERDICT_ACCEPT;
							rld_out_q <= 1'b1;
							state_q   <= ST_RLD0;
						end
						ACT_MATCH: begin
							sp_q    <= sp_dec;
							res_q   <= VERDICT_MORE;
							state_q <= ST_OUT;
						end
						ACT_EXPAND: begin
							if (overflow) begin
								res_q     <= VERDICT_REJECT;
								rld_out_q <= 1'b1;
								state_q   <= ST_RLD0;
							end else begin
								sp_q    <= sp_dec;
								prod_q  <= act.prod;
								cnt_q   <= prod_len(act.prod);
								state_q <= (prod_len(act.prod) == 2'd0) ? ST_READ : ST_PUSH;
							end
						end
						default: begin
							res_q     <= VERDICT_REJECT;
							rld_out_q <= 1'b1;
							state_q   <= ST_RLD0;
						end
					endcase
				end
				ST_PUSH: begin
					sp_q  <= sp_q + SPW'(1);
					cnt_q <= cnt_dec;
					if (cnt_q == 2'd1) begin
						state_q <= ST_READ;
					end
				end
				ST_RLD0: state_q <= ST_RLD1;
				ST_RLD1: begin
					sp_q      <= SPW'(2);
					rld_out_q <= 1'b0;
					state_q   <= rld_out_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: holds a result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			verdict_q <= res_q;
			depth_q   <= DEPTH_W'(sp_q);
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign stack_depth = depth_q;

endmodule

@@ hw/rtl/ll1er_checker.sv @@
// Port-level checks for the LL(1) expression recognizer, bound to its top.
// Depends on ll1er_pkg and ll1_expression_recognizer.

module ll1er_port_checker import ll1er_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         verdict,
	input logic [DEPTH_W-1:0] stack_depth,
	input logic               out_valid,
	input logic               out_ready
);

	// A shown verdict is always one of the three defined codes.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_MORE || verdict == VERDICT_ACCEPT ||
			verdict == VERDICT_REJECT))
		else $error("verdict code out of range");

	// After an accept or a reject the stack has reloaded to two entries.
	a_reload_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict != VERDICT_MORE) |-> stack_depth == DEPTH_W'(2))
		else $error("stack not reloaded after verdict");

	// Taking an item makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready again right after taking an item");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(verdict) &&
			$stable(stack_depth)))
		else $error("stalled result changed");

endmodule

bind ll1_expression_recognizer ll1er_port_checker u_ll1er_checker (.*);

@@ tb/ll1er_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the LL(1) expression recognizer: keeps its own parse stack,
// predicts the result item for every accepted character and checks each result item.
// Depends on ll1er_pkg for symbol and verdict codes.

module ll1er_checker import ll1er_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_in,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         verdict,
	input  logic [DEPTH_W-1:0] stack_depth,
	input  logic               out_valid,
	input  logic               out_ready,
	output int                 fail_count,
	output int                 pending_count
);

	localparam int STEP_LIMIT = 4 * DEPTH + 16;

	// How a character is seen by the grammar.
	typedef enum int {
		K_PLUS, K_STAR, K_LP, K_RP, K_ID, K_END, K_BAD
	} char_kind_t;

	// Grammar rules; R_NONE is a hole in the parse table.
	typedef enum int {
		R_NONE, R_ADD, R_MUL, R_PAREN, R_TH, R_FU, R_ID, R_EMPTY
	} rule_t;

	typedef struct packed {
		verdict_t           v;
		logic [DEPTH_W-1:0] depth;
	} parse_result_t;

	sym_t          parse_stack [DEPTH];
	int unsigned   parse_sp;
	parse_result_t pending_verdicts[$];
	int            n_fail;

	function automatic char_kind_t kind_of(logic [7:0] c);
		if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z))
			return K_ID;
		case (c)
			CH_PLUS: return K_PLUS;
			CH_STAR: return K_STAR;
			CH_LP:   return K_LP;
			CH_RP:   return K_RP;
			CH_END:  return K_END;
			default: return K_BAD;
		endcase
	endfunction

	function automatic sym_t terminal_of(char_kind_t k);
		case (k)
			K_PLUS:  return SYM_PLUS;
			K_STAR:  return SYM_STAR;
			K_LP:    return SYM_LP;
			K_RP:    return SYM_RP;
			K_ID:    return SYM_ID;
			default: return SYM_END;
		endcase
	endfunction

	// Predictive table: which rule expands a nonterminal on a lookahead.
	function automatic rule_t rule_for(sym_t nt, char_kind_t k);
		rule_t r;
		r = R_NONE;
		case (nt)
			SYM_E: if (k == K_LP || k == K_ID) r = R_TH;
			SYM_H: begin
				if (k == K_PLUS) r = R_ADD;
				else if (k == K_RP || k == K_END) r = R_EMPTY;
			end
			SYM_T: if (k == K_LP || k == K_ID) r = R_FU;
			SYM_U: begin
				if (k == K_STAR) r = R_MUL;
				else if (k == K_PLUS || k == K_RP || k == K_END) r = R_EMPTY;
			end
			SYM_F: begin
				if (k == K_LP) r = R_PAREN;
				else if (k == K_ID) r = R_ID;
			end
			default: r = R_NONE;
		endcase
		return r;
	endfunction

	function automatic int rule_len(rule_t r);
		case (r)
			R_ADD, R_MUL, R_PAREN: return 3;
			R_TH, R_FU:            return 2;
			R_ID:                  return 1;
			default:               return 0;
		endcase
	endfunction

	// Right-hand side symbol at position idx, left to right.
	function automatic sym_t rule_sym(rule_t r, int idx);
		case (r)
			R_ADD:   return (idx == 0) ? SYM_PLUS : (idx == 1) ? SYM_T : SYM_H;
			R_MUL:   return (idx == 0) ? SYM_STAR : (idx == 1) ? SYM_F : SYM_U;
			R_PAREN: return (idx == 0) ? SYM_LP : (idx == 1) ? SYM_E : SYM_RP;
			R_TH:    return (idx == 0) ? SYM_T : SYM_H;
			R_FU:    return (idx == 0) ? SYM_F : SYM_U;
			R_ID:    return SYM_ID;
			default: return SYM_END;
		endcase
	endfunction

	function automatic void reload_stack();
		int i;
		for (i = 0; i < DEPTH; i++)
			parse_stack[i] = SYM_END;
		parse_stack[1] = SYM_E;
		parse_sp = 2;
	endfunction

	// Run the parser on one character and return the verdict it reaches.
	function automatic verdict_t parse_char(logic [7:0] c);
		char_kind_t k;
		rule_t      r;
		sym_t       top;
		verdict_t   v;
		bit         done;
		int         iter;
		int         n;
		int         j;
		k = kind_of(c);
		v = VERDICT_REJECT;
		done = (k == K_BAD);
		for (iter = 0; iter < STEP_LIMIT && !done; iter++) begin
			if (parse_sp == 0 || parse_sp > DEPTH) begin
				done = 1;
			end else begin
				top = parse_stack[parse_sp - 1];
				if (top == SYM_END) begin
					if (k == K_END) v = VERDICT_ACCEPT;
					done = 1;
				end else if (top >= SYM_PLUS) begin
					// A terminal on top must match the character.
					if (top == terminal_of(k)) begin
						parse_sp--;
						v = VERDICT_MORE;
					end
					done = 1;
				end else begin
					r = rule_for(top, k);
					if (r == R_NONE) begin
						done = 1;
					end else begin
						parse_sp--;
						n = rule_len(r);
						if (parse_sp + n > DEPTH) begin
							done = 1;
						end else begin
							for (j = n - 1; j >= 0; j--) begin
								parse_stack[parse_sp] = rule_sym(r, j);
								parse_sp++;
							end
						end
					end
				end
			end
		end
		if (v != VERDICT_MORE)
			reload_stack();
		return v;
	endfunction

	// Check result items first, then predict for a character taken on the same edge.
	always @(posedge clk or negedge arst_n) begin
		parse_result_t exp_res;
		if (!arst_n) begin
			reload_stack();
			pending_verdicts.delete();
			n_fail = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_verdicts.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected result item, verdict %0d depth %0d",
						$time, verdict, stack_depth);
				end else begin
					exp_res = pending_verdicts.pop_front();
					if (verdict !== exp_res.v) begin
						n_fail++;
						$display("%0t: verdict expected %0d, got %0d",
							$time, exp_res.v, verdict);
					end
					if (stack_depth !== exp_res.depth) begin
						n_fail++;
						$display("%0t: stack_depth expected %0d, got %0d",
							$time, exp_res.depth, stack_depth);
					end
				end
			end
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				exp_res.v = parse_char(char_in);
				exp_res.depth = parse_sp[DEPTH_W-1:0];
				pending_verdicts.push_back(exp_res);
			end
			fail_count <= n_fail;
			pending_count <= pending_verdicts.size();
		end
	end

endmodule

@@ tb/tb_ll1_expression_recognizer.sv @@
`timescale 1ns / 1ps
// Testbench top for the LL(1) expression recognizer: clock, reset, character
// stimulus and result backpressure, with ll1er_checker doing the scoring.
// Depends on ll1er_pkg, ll1_expression_recognizer and ll1er_checker.

module tb_ll1_expression_recognizer;
	import ll1er_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 2000;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 100;
	localparam int LONG_HOLD    = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic [7:0]         char_in = 8'h00;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         verdict;
	logic [DEPTH_W-1:0] stack_depth;
	logic               out_valid;
	logic               out_ready = 1'b0;
	int                 fail_count;
	int                 pending_count;
	int                 cycle_count = 0;
	logic [7:0]         text_q[$];

	always #10 clk = ~clk;

	ll1_expression_recognizer #(.STACK_DEPTH(STACK_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .char_in(char_in), .in_valid(in_valid),
		.in_ready(in_ready), .verdict(verdict), .stack_depth(stack_depth),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	ll1er_checker #(.DEPTH(STACK_DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n), .char_in(char_in), .in_valid(in_valid),
		.in_ready(in_ready), .verdict(verdict), .stack_depth(stack_depth),
		.out_valid(out_valid), .out_ready(out_ready),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1))
			return CH_LC_A + 8'($urandom_range(0, 25));
		return CH_UC_A + 8'($urandom_range(0, 25));
	endfunction

	// Well-formed expression text, nesting limited by nest.
	function automatic void gen_factor(int nest);
		if (nest > 0 && $urandom_range(0, 2) == 0) begin
			text_q.push_back(CH_LP);
			gen_expr(nest - 1);
			text_q.push_back(CH_RP);
		end else begin
			text_q.push_back(random_letter());
		end
	endfunction

	function automatic void gen_term(int nest);
		int n;
		gen_factor(nest);
		n = $urandom_range(0, 2);
		repeat (n) begin
			text_q.push_back(CH_STAR);
			gen_factor(nest);
		end
	endfunction

	function automatic void gen_expr(int nest);
		int n;
		gen_term(nest);
		n = $urandom_range(0, 2);
		repeat (n) begin
			text_q.push_back(CH_PLUS);
			gen_term(nest);
		end
	endfunction

	function automatic void load_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// Offer one character and wait for the edge that takes it.
	task automatic send_char(logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_text(output int sent);
		sent = text_q.size();
		while (text_q.size() > 0)
			send_char(text_q.pop_front());
	endtask

	// Result side: random stalls, plus one long hold-off so the block backs up.
	initial begin : result_sink
		int run_len;
		int gap;
		int bursts;
		bursts = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			run_len = $urandom_range(1, 40);
			out_ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			bursts++;
			if (bursts == 60) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Run limit.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int total;
		int r;
		int pos;
		int nest;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: letter extremes, every operator, bytes outside the alphabet,
		// a table hole on '(', terminal mismatch, end marker on a non-$ character,
		// stack overflow from nesting, and an empty string.
		load_text("z$");
		load_text("(Z+a)*A$");
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		load_text("a(");
		load_text("(a$");
		load_text("a)");
		load_text("(((((");
		load_text("$");
		send_text(sent);

		// Random: mostly complete expressions, some broken ones and noise.
		total = 0;
		while (total < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				gen_expr($urandom_range(0, 3));
				text_q.push_back(CH_END);
			end else if (r < 80) begin
				gen_expr($urandom_range(0, 3));
				text_q.push_back(CH_END);
				pos = $urandom_range(0, text_q.size() - 1);
				text_q[pos] = 8'($urandom_range(0, 255));
			end else if (r < 88) begin
				repeat ($urandom_range(1, 6))
					text_q.push_back(8'($urandom_range(0, 255)));
			end else if (r < 94) begin
				// Expression cut short; the next string runs on from it.
				gen_expr($urandom_range(0, 2));
			end else begin
				// Deep nesting, past the stack size at five or more levels.
				nest = $urandom_range(3, 7);
				repeat (nest) text_q.push_back(CH_LP);
				gen_expr(1);
				repeat (nest) text_q.push_back(CH_RP);
				text_q.push_back(CH_END);
			end
			send_text(sent);
			total += sent;
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch a while for strays.
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
